FILE: hdl/capr_pkg.sv
// Shared types, codes and sizing constants for the checker pixel-to-RGB converter.
// Used by every module under hdl except capr_ram; depends on nothing.
`default_nettype none

package capr_pkg;

  // Sizing
  localparam int COORD_BITS = 12;
  localparam int PAL_DEPTH  = 256;
  localparam int PAL_AW     = $clog2(PAL_DEPTH);
  localparam logic [8:0] PAL_LIMIT = 9'(PAL_DEPTH);

  localparam logic [11:0] COORD_MASK =
    (COORD_BITS >= 12) ? 12'hFFF : 12'((32'd1 << COORD_BITS) - 32'd1);

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);
  localparam logic [Q_CW:0]   Q_LIMIT = (Q_CW + 1)'(Q_DEPTH);
  localparam logic [Q_AW-1:0] Q_LAST  = Q_AW'(Q_DEPTH - 1);

  // Result buffer in the back end
  localparam int OB_DEPTH = 4;
  localparam int OB_AW    = $clog2(OB_DEPTH);
  localparam int OB_CW    = $clog2(OB_DEPTH + 1);
  localparam logic [OB_CW:0]   OB_LIMIT = (OB_CW + 1)'(OB_DEPTH);
  localparam logic [OB_AW-1:0] OB_LAST  = OB_AW'(OB_DEPTH - 1);

  // Item modes
  localparam logic [1:0] MODE_PIXEL     = 2'd0;
  localparam logic [1:0] MODE_PAL_WRITE = 2'd1;
  localparam logic [1:0] MODE_PAL_CLEAR = 2'd2;

  // Pixel formats
  localparam logic [2:0] FMT_GRAY     = 3'd0;
  localparam logic [2:0] FMT_GRAYA    = 3'd1;
  localparam logic [2:0] FMT_RGB      = 3'd2;
  localparam logic [2:0] FMT_RGBA     = 3'd3;
  localparam logic [2:0] FMT_INDEXED  = 3'd4;
  localparam logic [2:0] FMT_INDEXEDA = 3'd5;

  // Result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PAL  = 2'd1;
  localparam logic [1:0] ST_BAD_FMT = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_CHECK_SIZE  = 2'd0;
  localparam logic [1:0] REG_CHECK_LIGHT = 2'd1;
  localparam logic [1:0] REG_CHECK_DARK  = 2'd2;

  // Register reset values
  localparam logic [11:0] CHECK_SIZE_RST  = 12'd8;
  localparam logic [7:0]  CHECK_LIGHT_RST = 8'd153;
  localparam logic [7:0]  CHECK_DARK_RST  = 8'd102;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  format;
    logic [7:0]  chan0;
    logic [7:0]  chan1;
    logic [7:0]  chan2;
    logic [7:0]  alpha;
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  map_index;
    logic [7:0]  map_red;
    logic [7:0]  map_green;
    logic [7:0]  map_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [11:0] check_size;
    logic [7:0]  check_light;
    logic [7:0]  check_dark;
  } cfg_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic [1:0]  status;
    logic        use_pal;
    logic [7:0]  alpha;
    logic [7:0]  check;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [23:0] pal_rgb;
  } pix_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/capr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module capr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/capr_front.sv
// Front end: accepts items, keeps the palette and its valid bits, classifies pixels.
// Depends on capr_pkg and capr_ram.
`default_nettype none

module capr_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire capr_pkg::cfg_t          cfg,
  input  wire logic                    push,
  input  wire capr_pkg::in_item_t      in_data,
  output logic                         full,
  input  wire logic [capr_pkg::Q_CW-1:0] q_count,
  output logic                         cmd_valid,
  output capr_pkg::pix_cmd_t           cmd
);

  logic                          accept;
  logic                          is_pix;
  logic                          is_wr;
  logic                          is_clr;
  logic [capr_pkg::Q_CW:0]       inflight;
  logic                          wr_ok;
  logic                          rd_ok;
  logic [capr_pkg::PAL_AW-1:0]   wr_addr;
  logic [capr_pkg::PAL_AW-1:0]   rd_addr;
  logic [23:0]                   pal_rdata;
  logic [capr_pkg::PAL_DEPTH-1:0] valid_r;
  logic [capr_pkg::PAL_DEPTH-1:0] valid_nxt;
  logic                          loaded_r;
  logic                          loaded_nxt;
  logic                          s1_valid_r;
  logic                          s1_hit_r;
  logic                          hit_nxt;
  capr_pkg::pix_cmd_t            s1_cmd_r;
  capr_pkg::pix_cmd_t            cmd_nxt;
  logic [11:0]                   size_m;
  logic                          light_sq;

  // Hold off input while the queue cannot absorb what is in flight
  assign inflight = {1'b0, q_count} + {{capr_pkg::Q_CW{1'b0}}, s1_valid_r};
  assign full     = inflight >= capr_pkg::Q_LIMIT;
  assign accept   = push && !full;

  assign is_pix = accept && (in_data.mode == capr_pkg::MODE_PIXEL);
  assign is_wr  = accept && (in_data.mode == capr_pkg::MODE_PAL_WRITE);
  assign is_clr = accept && (in_data.mode == capr_pkg::MODE_PAL_CLEAR);

  assign wr_ok   = {1'b0, in_data.map_index} < capr_pkg::PAL_LIMIT;
  assign rd_ok   = {1'b0, in_data.chan0} < capr_pkg::PAL_LIMIT;
  assign wr_addr = in_data.map_index[capr_pkg::PAL_AW-1:0];
  assign rd_addr = in_data.chan0[capr_pkg::PAL_AW-1:0];

  capr_ram #(
    .WIDTH (24),
    .DEPTH (capr_pkg::PAL_DEPTH)
  ) u_pal (
    .clk   (clk),
    .we    (is_wr && wr_ok),
    .waddr (wr_addr),
    .wdata ({in_data.map_red, in_data.map_green, in_data.map_blue}),
    .re    (is_pix),
    .raddr (rd_addr),
    .rdata (pal_rdata)
  );

  // Drop all entries on the first write after reset or clear
  always_comb begin
    valid_nxt  = valid_r;
    loaded_nxt = loaded_r;
    if (is_wr) begin
      if (!loaded_r) begin
        valid_nxt = '0;
      end
      if (wr_ok) begin
        valid_nxt[wr_addr] = 1'b1;
      end
      loaded_nxt = 1'b1;
    end else if (is_clr) begin
      loaded_nxt = 1'b0;
    end
  end

  // Classify the pixel
  assign size_m   = cfg.check_size & capr_pkg::COORD_MASK;
  assign light_sq = ((in_data.row & size_m) ^ (in_data.col & size_m)) != 12'd0;
  assign hit_nxt  = rd_ok && valid_r[rd_addr];

  always_comb begin
    cmd_nxt         = '0;
    cmd_nxt.check   = light_sq ? cfg.check_light : cfg.check_dark;
    cmd_nxt.alpha   = capr_pkg::ALPHA_OPAQUE;
    cmd_nxt.red     = in_data.chan0;
    cmd_nxt.green   = in_data.chan1;
    cmd_nxt.blue    = in_data.chan2;
    case (in_data.format)
      capr_pkg::FMT_GRAY: begin
        cmd_nxt.green = in_data.chan0;
        cmd_nxt.blue  = in_data.chan0;
      end
      capr_pkg::FMT_GRAYA: begin
        cmd_nxt.green = in_data.chan0;
        cmd_nxt.blue  = in_data.chan0;
        cmd_nxt.alpha = in_data.alpha;
      end
      capr_pkg::FMT_RGB: begin
        cmd_nxt.status = capr_pkg::ST_OK;
      end
      capr_pkg::FMT_RGBA: begin
        cmd_nxt.alpha = in_data.alpha;
      end
      capr_pkg::FMT_INDEXED: begin
        cmd_nxt.use_pal = 1'b1;
        cmd_nxt.status  = loaded_r ? capr_pkg::ST_OK : capr_pkg::ST_NO_PAL;
      end
      capr_pkg::FMT_INDEXEDA: begin
        cmd_nxt.use_pal = 1'b1;
        cmd_nxt.alpha   = in_data.alpha;
        cmd_nxt.status  = loaded_r ? capr_pkg::ST_OK : capr_pkg::ST_NO_PAL;
      end
      default: begin
        cmd_nxt.status = capr_pkg::ST_BAD_FMT;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      loaded_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      loaded_r   <= loaded_nxt;
      s1_valid_r <= is_pix;
    end
  end

  // Pixel stage payload
  always_ff @(posedge clk) begin
    if (is_pix) begin
      s1_cmd_r <= cmd_nxt;
      s1_hit_r <= hit_nxt;
    end
  end

  // Attach palette data; entries never written read as black
  always_comb begin
    cmd         = s1_cmd_r;
    cmd.pal_rgb = s1_hit_r ? pal_rdata : 24'd0;
  end

  assign cmd_valid = s1_valid_r;

endmodule

`default_nettype wire

FILE: hdl/capr_queue.sv
// Short queue of classified pixels between front and back end.
// Depends on capr_pkg.
`default_nettype none

module capr_queue (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      wr_en,
  input  wire capr_pkg::pix_cmd_t        wr_data,
  input  wire logic                      rd_en,
  output capr_pkg::pix_cmd_t             head,
  output logic [capr_pkg::Q_CW-1:0]      count
);

  capr_pkg::pix_cmd_t              mem_r [capr_pkg::Q_DEPTH];
  logic [capr_pkg::Q_AW-1:0]       wptr_r;
  logic [capr_pkg::Q_AW-1:0]       wptr_nxt;
  logic [capr_pkg::Q_AW-1:0]       rptr_r;
  logic [capr_pkg::Q_AW-1:0]       rptr_nxt;
  logic [capr_pkg::Q_CW-1:0]       count_r;
  logic [capr_pkg::Q_CW-1:0]       count_nxt;

  // Advance pointers and count
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (wr_en) begin
      wptr_nxt = (wptr_r == capr_pkg::Q_LAST) ? '0 : wptr_r + 1'b1;
    end
    if (rd_en) begin
      rptr_nxt = (rptr_r == capr_pkg::Q_LAST) ? '0 : rptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  assign head  = mem_r[rptr_r];
  assign count = count_r;

endmodule

`default_nettype wire

FILE: hdl/capr_back.sv
// Back end: blends colour over the checker grey and buffers results.
// Depends on capr_pkg.
`default_nettype none

module capr_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [capr_pkg::Q_CW-1:0] q_count,
  input  wire capr_pkg::pix_cmd_t        q_head,
  output logic                           q_pop,
  input  wire logic                      pop,
  output logic                           empty,
  output capr_pkg::out_item_t            out_data
);

  logic                            take;
  logic [capr_pkg::OB_CW:0]        ob_inflight;
  logic [7:0]                      colour [3];
  logic signed [9:0]               weight;
  logic signed [8:0]               diff [3];
  logic signed [18:0]              prod_nxt [3];
  logic signed [18:0]              p_prod_r [3];
  logic signed [18:0]              shifted [3];
  logic [7:0]                      p_check_r;
  logic [1:0]                      p_status_r;
  logic                            p_azero_r;
  logic                            p_valid_r;
  logic [7:0]                      res [3];
  capr_pkg::out_item_t             res_item;
  capr_pkg::out_item_t             ob_mem_r [capr_pkg::OB_DEPTH];
  logic [capr_pkg::OB_AW-1:0]      ob_wptr_r;
  logic [capr_pkg::OB_AW-1:0]      ob_wptr_nxt;
  logic [capr_pkg::OB_AW-1:0]      ob_rptr_r;
  logic [capr_pkg::OB_AW-1:0]      ob_rptr_nxt;
  logic [capr_pkg::OB_CW-1:0]      ob_count_r;
  logic [capr_pkg::OB_CW-1:0]      ob_count_nxt;
  logic                            ob_rd;

  // Take a pixel only when the result buffer has room for it
  assign ob_inflight = {1'b0, ob_count_r} + {{capr_pkg::OB_CW{1'b0}}, p_valid_r};
  assign take        = (q_count != '0) && (ob_inflight < capr_pkg::OB_LIMIT);
  assign q_pop       = take;

  // Select colour source and multiply the difference by alpha + 1
  assign colour[0] = q_head.use_pal ? q_head.pal_rgb[23:16] : q_head.red;
  assign colour[1] = q_head.use_pal ? q_head.pal_rgb[15:8]  : q_head.green;
  assign colour[2] = q_head.use_pal ? q_head.pal_rgb[7:0]   : q_head.blue;
  assign weight    = $signed({2'b00, q_head.alpha} + 10'd1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]     = $signed({1'b0, colour[i]}) - $signed({1'b0, q_head.check});
      prod_nxt[i] = diff[i] * weight;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_prod_r   <= prod_nxt;
      p_check_r  <= q_head.check;
      p_status_r <= q_head.status;
      p_azero_r  <= (q_head.alpha == 8'd0);
    end
  end

  // Finish the blend: check + floor(product / 256); check alone when alpha is zero, zero on a bad status
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = p_prod_r[i] >>> 8;
      if (p_status_r != capr_pkg::ST_OK) begin
        res[i] = 8'd0;
      end else if (p_azero_r) begin
        res[i] = p_check_r;
      end else begin
        res[i] = p_check_r + shifted[i][7:0];
      end
    end
    res_item.out_red   = res[0];
    res_item.out_green = res[1];
    res_item.out_blue  = res[2];
    res_item.status    = p_status_r;
  end

  // Result buffer
  assign empty = (ob_count_r == '0);
  assign ob_rd = pop && !empty;

  always_comb begin
    ob_wptr_nxt  = ob_wptr_r;
    ob_rptr_nxt  = ob_rptr_r;
    ob_count_nxt = ob_count_r;
    if (p_valid_r) begin
      ob_wptr_nxt = (ob_wptr_r == capr_pkg::OB_LAST) ? '0 : ob_wptr_r + 1'b1;
    end
    if (ob_rd) begin
      ob_rptr_nxt = (ob_rptr_r == capr_pkg::OB_LAST) ? '0 : ob_rptr_r + 1'b1;
    end
    if (p_valid_r && !ob_rd) begin
      ob_count_nxt = ob_count_r + 1'b1;
    end else if (ob_rd && !p_valid_r) begin
      ob_count_nxt = ob_count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wptr_r  <= '0;
      ob_rptr_r  <= '0;
      ob_count_r <= '0;
    end else begin
      ob_wptr_r  <= ob_wptr_nxt;
      ob_rptr_r  <= ob_rptr_nxt;
      ob_count_r <= ob_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid_r) begin
      ob_mem_r[ob_wptr_r] <= res_item;
    end
  end

  assign out_data = ob_mem_r[ob_rptr_r];

endmodule

`default_nettype wire

FILE: hdl/checker_alpha_pixel_to_rgb.sv
// Pixel-to-RGB converter with checker backdrop and palette: top level.
// A pixel passes the front register, queue, product register and result buffer.
// One item per clock while not full; one palette read and one multiply per channel.
// Reset (rst_n, synchronous, low): registers to defaults, palette valid bits
// cleared at once, queues emptied; no clearing pass.
// Depends on capr_pkg, capr_front, capr_queue and capr_back.
`default_nettype none

module checker_alpha_pixel_to_rgb (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire capr_pkg::in_item_t   in_data,
  output logic                      empty,
  input  wire logic                 pop,
  output capr_pkg::out_item_t       out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  capr_pkg::cfg_t                   cfg_r;
  capr_pkg::cfg_t                   cfg_nxt;
  logic                             cfg_wr;
  logic [1:0]                       reg_idx;
  logic                             cmd_valid;
  capr_pkg::pix_cmd_t               cmd;
  capr_pkg::pix_cmd_t               q_head;
  logic [capr_pkg::Q_CW-1:0]        q_count;
  logic                             q_pop;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        capr_pkg::REG_CHECK_SIZE:  cfg_nxt.check_size  = pwdata[11:0];
        capr_pkg::REG_CHECK_LIGHT: cfg_nxt.check_light = pwdata[7:0];
        capr_pkg::REG_CHECK_DARK:  cfg_nxt.check_dark  = pwdata[7:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_size  <= capr_pkg::CHECK_SIZE_RST;
      cfg_r.check_light <= capr_pkg::CHECK_LIGHT_RST;
      cfg_r.check_dark  <= capr_pkg::CHECK_DARK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read back
  always_comb begin
    case (reg_idx)
      capr_pkg::REG_CHECK_SIZE:  prdata = {20'd0, cfg_r.check_size};
      capr_pkg::REG_CHECK_LIGHT: prdata = {24'd0, cfg_r.check_light};
      capr_pkg::REG_CHECK_DARK:  prdata = {24'd0, cfg_r.check_dark};
      default:                   prdata = 32'd0;
    endcase
  end

  capr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .q_count   (q_count),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  capr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .rd_en   (q_pop),
    .head    (q_head),
    .count   (q_count)
  );

  capr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_count  (q_count),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
